/* rtl/dual_wheel_encoder_speed_meter_macros.svh */
// Assertion macros for the checker file of the encoder speed meter.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef DUAL_WHEEL_ENCODER_SPEED_METER_MACROS_SVH
`define DUAL_WHEEL_ENCODER_SPEED_METER_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define DWESM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define DWESM_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* rtl/dwesm_pkg.sv */
// Package of the dual wheel encoder speed meter: widths, reciprocal constants,
// codes and pipeline stage types. No dependencies.
package dwesm_pkg;

	// Sampling setup.
	localparam int unsigned TICKS_PER_SAMPLE = 2;
	localparam int unsigned SAMPLE_PERIOD_MS = 10;

	// Field and state widths.
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_W      = 16;
	localparam int CNT_W      = 32;
	localparam int MM_W       = 16;
	localparam int SPD_W      = 15;
	localparam int DIV_W      = 8;
	localparam int DIST_W     = 39;
	localparam int NUM_WHEELS = 2;
	localparam int WHEEL_LEFT  = 0;
	localparam int WHEEL_RIGHT = 1;
	localparam int PIPE_DEPTH  = 6;

	// Register reset values.
	localparam logic [MM_W-1:0]  MM_RESET    = MM_W'(580);
	localparam logic [SPD_W-1:0] LIMIT_RESET = SPD_W'(2500);

	// Speed path. Any delta wider than DELTA_W bits saturates to all ones,
	// which still clamps. The threshold (limit + 1) * period fits in THRESH_W bits.
	localparam int DELTA_W  = $clog2((longint'(1) << SPD_W) * SAMPLE_PERIOD_MS) + 1;
	localparam int PROD_W   = DELTA_W + MM_W;
	localparam int THRESH_W = $clog2((longint'(1) << SPD_W) * SAMPLE_PERIOD_MS + 1);
	localparam int SPEED_SHIFT = DELTA_W + 10;
	localparam longint unsigned SPEED_RECIP =
		((longint'(1) << SPEED_SHIFT) + SAMPLE_PERIOD_MS - 1) / SAMPLE_PERIOD_MS;
	localparam int SPEED_RECIP_W = $clog2(SPEED_RECIP + 1);
	localparam int SQ_W = THRESH_W + SPEED_RECIP_W;

	// Distance path. The forward count is also kept as hi * 1000 + lo.
	localparam int DIST_DIV = 1000;
	localparam int LO_W     = $clog2(DIST_DIV);
	localparam int HI_W     = $clog2(((longint'(1) << CNT_W) - 1) / DIST_DIV + 1);
	localparam int LPROD_W  = LO_W + MM_W;
	localparam int DIST_SHIFT = LPROD_W + 10;
	localparam longint unsigned DIST_RECIP =
		((longint'(1) << DIST_SHIFT) + DIST_DIV - 1) / DIST_DIV;
	localparam int DIST_RECIP_W = $clog2(DIST_RECIP + 1);
	localparam int DQ_W = LPROD_W + DIST_RECIP_W;
	localparam int LQ_W = MM_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_PULSE       = 2'd0,
		CMD_TICK        = 2'd1,
		CMD_FULL_RESET  = 2'd2,
		CMD_SPEED_RESET = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MM_PER_COUNT   = 2'd0,
		REG_LEFT_REVERSED  = 2'd1,
		REG_RIGHT_REVERSED = 2'd2,
		REG_SPEED_LIMIT    = 2'd3
	} cfg_idx_t;

	// What the filter stage does with the filtered speeds.
	typedef enum logic [1:0] {
		FILT_HOLD,
		FILT_SAMPLE,
		FILT_CLEAR
	} filt_op_t;

	typedef struct packed {
		logic [DELTA_W-1:0] delta;
		logic [HI_W-1:0]    hi;
		logic [LO_W-1:0]    lo;
		logic [CNT_W-1:0]   scount;
	} wheel_s2_t;

	typedef struct packed {
		logic [PROD_W-1:0]  prod;
		logic [DIST_W-1:0]  hm;
		logic [LPROD_W-1:0] lm;
		logic [CNT_W-1:0]   scount;
	} wheel_s3_t;

	typedef struct packed {
		logic                clamp;
		logic [THRESH_W-1:0] pl;
		logic [DIST_W-1:0]   hm;
		logic [LQ_W-1:0]     lq;
		logic [CNT_W-1:0]    scount;
	} wheel_s4_t;

	typedef struct packed {
		logic [SPD_W-1:0]  raw;
		logic [DIST_W-1:0] dist_mm;
		logic [CNT_W-1:0]  scount;
	} wheel_s5_t;

	typedef struct packed {
		logic [SPD_W-1:0]  spd;
		logic [DIST_W-1:0] dist_mm;
		logic [CNT_W-1:0]  scount;
	} wheel_s6_t;

endpackage

/* rtl/dwesm_if.sv */
// Valid/ready channel interfaces of the encoder speed meter: command in, result out.
// Depends on dwesm_pkg.
interface dwesm_cmd_if
	import dwesm_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic             left_pulse;
	logic             right_pulse;

	modport source (output valid, command, left_pulse, right_pulse, input ready);
	modport sink (input valid, command, left_pulse, right_pulse, output ready);
endinterface

interface dwesm_res_if
	import dwesm_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [SPD_W-1:0]         left_speed;
	logic [SPD_W-1:0]         right_speed;
	logic [CNT_W-1:0]         sample_sequence;
	logic                     new_sample;
	logic signed [CNT_W-1:0]  left_signed_count;
	logic signed [CNT_W-1:0]  right_signed_count;
	logic [DIST_W-1:0]        left_distance_mm;
	logic [DIST_W-1:0]        right_distance_mm;

	modport source (
		output valid, left_speed, right_speed, sample_sequence, new_sample,
			left_signed_count, right_signed_count, left_distance_mm, right_distance_mm,
		input ready
	);
	modport sink (
		input valid, left_speed, right_speed, sample_sequence, new_sample,
			left_signed_count, right_signed_count, left_distance_mm, right_distance_mm,
		output ready
	);
endinterface

/* rtl/dual_wheel_encoder_speed_meter.sv */
// Top level of the dual wheel encoder speed meter: counters, sample pipeline, filter.
// Depends on dwesm_pkg and the channel interfaces in dwesm_if.sv.
//
//   channel   direction  content
//   cmd       in         command, left_pulse, right_pulse
//   res       out        speeds, sequence, new_sample, signed counts, distances
//   cfg_*     in         register write, no handshake
//
// One transaction per cycle is accepted unless res stalls; results pass every stage register.
// The depth is set by the two multiplier stages of the speed and distance paths.
// Counters update as a command leaves stage 1, the filtered speeds as it leaves stage 5.
// A stalled result holds the output register; earlier stages keep filling any bubbles.
// Reset clears all counters, the filter and the registers to their defaults.
module dual_wheel_encoder_speed_meter
	import dwesm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	dwesm_cmd_if.sink            cmd,
	dwesm_res_if.source          res
);

	// Configuration registers.
	logic [MM_W-1:0]       mm_q;
	logic [NUM_WHEELS-1:0] rev_q;
	logic [SPD_W-1:0]      limit_q;

	// Block state.
	logic [CNT_W-1:0] fwd_q  [NUM_WHEELS];
	logic [CNT_W-1:0] scnt_q [NUM_WHEELS];
	logic [HI_W-1:0]  hi_q   [NUM_WHEELS];
	logic [LO_W-1:0]  lo_q   [NUM_WHEELS];
	logic [CNT_W-1:0] snap_q [NUM_WHEELS];
	logic [SPD_W-1:0] filt_q [NUM_WHEELS];
	logic [CNT_W-1:0] seq_q;
	logic [DIV_W-1:0] div_q;

	logic [CNT_W-1:0] fwd_n  [NUM_WHEELS];
	logic [CNT_W-1:0] scnt_n [NUM_WHEELS];
	logic [HI_W-1:0]  hi_n   [NUM_WHEELS];
	logic [LO_W-1:0]  lo_n   [NUM_WHEELS];
	logic [CNT_W-1:0] snap_n [NUM_WHEELS];
	logic [SPD_W-1:0] filt_n [NUM_WHEELS];
	logic [CNT_W-1:0] seq_n;
	logic [DIV_W-1:0] div_n;
	filt_op_t         op_n;

	// Pipeline stages.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic take_s1, take_s2, take_s3, take_s4, take_s5, take_s6;
	logic mv_s1, mv_s5;

	cmd_t                  cmd_s1;
	logic [NUM_WHEELS-1:0] pulse_s1;

	filt_op_t   op_s2, op_s3, op_s4, op_s5;
	logic [CNT_W-1:0] seq_s2, seq_s3, seq_s4, seq_s5, seq_s6;
	logic       new_s6;
	wheel_s2_t  w_s2 [NUM_WHEELS];
	wheel_s3_t  w_s3 [NUM_WHEELS];
	wheel_s4_t  w_s4 [NUM_WHEELS];
	wheel_s5_t  w_s5 [NUM_WHEELS];
	wheel_s6_t  w_s6 [NUM_WHEELS];

	wheel_s2_t  d_s2 [NUM_WHEELS];
	wheel_s3_t  d_s3 [NUM_WHEELS];
	wheel_s4_t  d_s4 [NUM_WHEELS];
	wheel_s5_t  d_s5 [NUM_WHEELS];

	logic [THRESH_W-1:0] thresh;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_q    <= MM_RESET;
			rev_q   <= '0;
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_MM_PER_COUNT:   mm_q <= cfg_data[MM_W-1:0];
				REG_LEFT_REVERSED:  rev_q[WHEEL_LEFT] <= cfg_data[0];
				REG_RIGHT_REVERSED: rev_q[WHEEL_RIGHT] <= cfg_data[0];
				REG_SPEED_LIMIT:    limit_q <= cfg_data[SPD_W-1:0];
			endcase
		end
	end

	// Handshake chain: a stage takes a new transaction when it is empty or its own moves on.
	assign take_s6 = !v_s6 || res.ready;
	assign take_s5 = !v_s5 || take_s6;
	assign take_s4 = !v_s4 || take_s5;
	assign take_s3 = !v_s3 || take_s4;
	assign take_s2 = !v_s2 || take_s3;
	assign take_s1 = !v_s1 || take_s2;
	assign mv_s1   = v_s1 && take_s2;
	assign mv_s5   = v_s5 && take_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (take_s1) v_s1 <= cmd.valid;
			if (take_s2) v_s2 <= v_s1;
			if (take_s3) v_s3 <= v_s2;
			if (take_s4) v_s4 <= v_s3;
			if (take_s5) v_s5 <= v_s4;
			if (take_s6) v_s6 <= v_s5;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1   <= CMD_PULSE;
			pulse_s1 <= '0;
		end else if (take_s1) begin
			cmd_s1   <= cmd_t'(cmd.command);
			pulse_s1 <= {cmd.right_pulse, cmd.left_pulse};
		end
	end

	// Stage 1: command decode and next counter state.
	always_comb begin
		logic [DIV_W-1:0] div_inc;
		div_inc = div_q + 1'b1;
		fwd_n  = fwd_q;
		scnt_n = scnt_q;
		hi_n   = hi_q;
		lo_n   = lo_q;
		snap_n = snap_q;
		seq_n  = seq_q;
		div_n  = div_q;
		op_n   = FILT_HOLD;
		unique case (cmd_s1)
			CMD_PULSE: begin
				for (int w = 0; w < NUM_WHEELS; w++) begin
					if (pulse_s1[w]) begin
						fwd_n[w]  = fwd_q[w] + 1'b1;
						scnt_n[w] = rev_q[w] ? scnt_q[w] - 1'b1 : scnt_q[w] + 1'b1;
						// The hi/lo split restarts when the forward count wraps.
						if (fwd_q[w] == '1) begin
							hi_n[w] = '0;
							lo_n[w] = '0;
						end else if (lo_q[w] == LO_W'(DIST_DIV - 1)) begin
							hi_n[w] = hi_q[w] + 1'b1;
							lo_n[w] = '0;
						end else begin
							lo_n[w] = lo_q[w] + 1'b1;
						end
					end
				end
			end
			CMD_TICK: begin
				if (div_inc >= DIV_W'(TICKS_PER_SAMPLE)) begin
					div_n  = '0;
					seq_n  = seq_q + 1'b1;
					op_n   = FILT_SAMPLE;
					snap_n = fwd_q;
				end else begin
					div_n = div_inc;
				end
			end
			CMD_FULL_RESET: begin
				for (int w = 0; w < NUM_WHEELS; w++) begin
					fwd_n[w]  = '0;
					scnt_n[w] = '0;
					hi_n[w]   = '0;
					lo_n[w]   = '0;
					snap_n[w] = '0;
				end
				seq_n = '0;
				div_n = '0;
				op_n  = FILT_CLEAR;
			end
			CMD_SPEED_RESET: begin
				snap_n = fwd_q;
				seq_n  = '0;
				div_n  = '0;
				op_n   = FILT_CLEAR;
			end
		endcase
	end

	// Stage 1: forward-count delta since the last sample, saturated for the speed path.
	always_comb begin
		logic [CNT_W-1:0] delta;
		for (int w = 0; w < NUM_WHEELS; w++) begin
			delta = fwd_q[w] - snap_q[w];
			d_s2[w].delta  = (|delta[CNT_W-1:DELTA_W]) ? '1 : delta[DELTA_W-1:0];
			d_s2[w].hi     = hi_n[w];
			d_s2[w].lo     = lo_n[w];
			d_s2[w].scount = scnt_n[w];
		end
	end

	// Counter state commits as the command leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < NUM_WHEELS; w++) begin
				fwd_q[w]  <= '0;
				scnt_q[w] <= '0;
				hi_q[w]   <= '0;
				lo_q[w]   <= '0;
				snap_q[w] <= '0;
			end
			seq_q <= '0;
			div_q <= '0;
		end else if (mv_s1) begin
			fwd_q  <= fwd_n;
			scnt_q <= scnt_n;
			hi_q   <= hi_n;
			lo_q   <= lo_n;
			snap_q <= snap_n;
			seq_q  <= seq_n;
			div_q  <= div_n;
		end
	end

	// Stage 2: products of the delta and of the count split with the travel per pulse.
	always_comb begin
		for (int w = 0; w < NUM_WHEELS; w++) begin
			d_s3[w].prod   = PROD_W'(w_s2[w].delta) * PROD_W'(mm_q);
			d_s3[w].hm     = DIST_W'(w_s2[w].hi) * DIST_W'(mm_q);
			d_s3[w].lm     = LPROD_W'(w_s2[w].lo) * LPROD_W'(mm_q);
			d_s3[w].scount = w_s2[w].scount;
		end
	end

	// Stage 3: clamp test and the low part of the distance divided by 1000.
	assign thresh = THRESH_W'((THRESH_W'(limit_q) + THRESH_W'(1)) * THRESH_W'(SAMPLE_PERIOD_MS));

	always_comb begin
		logic [DQ_W-1:0] lq_full;
		for (int w = 0; w < NUM_WHEELS; w++) begin
			lq_full = DQ_W'(w_s3[w].lm) * DQ_W'(DIST_RECIP);
			d_s4[w].clamp  = w_s3[w].prod >= PROD_W'(thresh);
			d_s4[w].pl     = w_s3[w].prod[THRESH_W-1:0];
			d_s4[w].hm     = w_s3[w].hm;
			d_s4[w].lq     = lq_full[DIST_SHIFT +: LQ_W];
			d_s4[w].scount = w_s3[w].scount;
		end
	end

	// Stage 4: raw speed as product over the sample period, and the full distance.
	always_comb begin
		logic [SQ_W-1:0] sq;
		for (int w = 0; w < NUM_WHEELS; w++) begin
			sq = SQ_W'(w_s4[w].pl) * SQ_W'(SPEED_RECIP);
			d_s5[w].raw     = w_s4[w].clamp ? limit_q : sq[SPEED_SHIFT +: SPD_W];
			d_s5[w].dist_mm = w_s4[w].hm + DIST_W'(w_s4[w].lq);
			d_s5[w].scount  = w_s4[w].scount;
		end
	end

	// Stage 5: low-pass filter y = (y + 3x) / 4.
	always_comb begin
		logic [SPD_W+1:0] sum;
		for (int w = 0; w < NUM_WHEELS; w++) begin
			sum = (SPD_W+2)'(filt_q[w]) + (SPD_W+2)'({w_s5[w].raw, 1'b0})
				+ (SPD_W+2)'(w_s5[w].raw);
			unique case (op_s5)
				FILT_SAMPLE: filt_n[w] = sum[SPD_W+1:2];
				FILT_CLEAR:  filt_n[w] = '0;
				FILT_HOLD:   filt_n[w] = filt_q[w];
				default:     filt_n[w] = filt_q[w];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < NUM_WHEELS; w++) filt_q[w] <= '0;
		end else if (mv_s5) begin
			filt_q <= filt_n;
		end
	end

	// Stage registers.
	always_ff @(posedge clk) begin
		if (take_s2) begin
			op_s2  <= op_n;
			seq_s2 <= seq_n;
			w_s2   <= d_s2;
		end
		if (take_s3) begin
			op_s3  <= op_s2;
			seq_s3 <= seq_s2;
			w_s3   <= d_s3;
		end
		if (take_s4) begin
			op_s4  <= op_s3;
			seq_s4 <= seq_s3;
			w_s4   <= d_s4;
		end
		if (take_s5) begin
			op_s5  <= op_s4;
			seq_s5 <= seq_s4;
			w_s5   <= d_s5;
		end
		if (take_s6) begin
			seq_s6 <= seq_s5;
			new_s6 <= op_s5 == FILT_SAMPLE;
			for (int w = 0; w < NUM_WHEELS; w++) begin
				w_s6[w].spd     <= filt_n[w];
				w_s6[w].dist_mm <= w_s5[w].dist_mm;
				w_s6[w].scount  <= w_s5[w].scount;
			end
		end
	end

	// Channel outputs.
	assign cmd.ready              = take_s1;
	assign res.valid              = v_s6;
	assign res.left_speed         = w_s6[WHEEL_LEFT].spd;
	assign res.right_speed        = w_s6[WHEEL_RIGHT].spd;
	assign res.sample_sequence    = seq_s6;
	assign res.new_sample         = new_s6;
	assign res.left_signed_count  = signed'(w_s6[WHEEL_LEFT].scount);
	assign res.right_signed_count = signed'(w_s6[WHEEL_RIGHT].scount);
	assign res.left_distance_mm   = w_s6[WHEEL_LEFT].dist_mm;
	assign res.right_distance_mm  = w_s6[WHEEL_RIGHT].dist_mm;

endmodule

/* rtl/dwesm_checker.sv */
// Port-level checker of the encoder speed meter and its bind to the top level.
// Depends on dwesm_pkg and dual_wheel_encoder_speed_meter_macros.svh.
`include "dual_wheel_encoder_speed_meter_macros.svh"

module dwesm_checker
	import dwesm_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             cmd_valid,
	input logic             cmd_ready,
	input logic             res_valid,
	input logic             res_ready,
	input logic             res_new_sample,
	input logic [CNT_W-1:0] res_sequence,
	input logic [SPD_W-1:0] res_left_speed,
	input logic [SPD_W-1:0] res_right_speed
);

	logic cmd_fire;
	logic res_fire;
	logic [$clog2(PIPE_DEPTH+1)-1:0] outstanding_q;
	logic             have_prev_q;
	logic [CNT_W-1:0] last_seq_q;
	logic [SPD_W-1:0] last_left_q;
	logic [SPD_W-1:0] last_right_q;

	assign cmd_fire = cmd_valid && cmd_ready;
	assign res_fire = res_valid && res_ready;

	// Transactions in flight, and the previous result seen.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
			have_prev_q   <= 1'b0;
			last_seq_q    <= '0;
			last_left_q   <= '0;
			last_right_q  <= '0;
		end else begin
			if (cmd_fire && !res_fire) outstanding_q <= outstanding_q + 1'b1;
			else if (res_fire && !cmd_fire) outstanding_q <= outstanding_q - 1'b1;
			if (res_fire) begin
				have_prev_q  <= 1'b1;
				last_seq_q   <= res_sequence;
				last_left_q  <= res_left_speed;
				last_right_q <= res_right_speed;
			end
		end
	end

	`DWESM_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid, "result dropped while stalled")
	`DWESM_ASSERT_NEVER(a_no_extra, res_fire && outstanding_q == '0, "result without a command")
	`DWESM_ASSERT(a_seq_step, res_fire && res_new_sample && have_prev_q |-> res_sequence == last_seq_q + 1'b1, "sample sequence did not step by one")
	`DWESM_ASSERT(a_speed_steady, res_fire && !res_new_sample && have_prev_q |-> (res_left_speed == last_left_q || res_left_speed == '0) && (res_right_speed == last_right_q || res_right_speed == '0), "speed changed without a sample")

endmodule

bind dual_wheel_encoder_speed_meter dwesm_checker u_dwesm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_new_sample  (res.new_sample),
	.res_sequence    (res.sample_sequence),
	.res_left_speed  (res.left_speed),
	.res_right_speed (res.right_speed)
);
